/* design/bmha_pkg.sv */
// Shared types, codes and constants for the burst measurement history averager.
// Used by bmha_store, bmha_div and burst_measurement_history_avg_top.
`default_nettype none

package bmha_pkg;

   // Operation codes of a request beat.
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_AVG    = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // Result kinds of a response beat.
   localparam logic KIND_AVG    = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

   // Which accumulator the shared divider is working on.
   typedef enum logic [1:0] {
      LANE_RSSI = 2'd0,
      LANE_TOA  = 2'd1,
      LANE_CI   = 2'd2
   } lane_type;

   // Field widths.
   localparam int FN_W    = 22;
   localparam int VAL_W   = 16;
   localparam int RSSI_W  = 8;
   localparam int BACK_W  = 6;
   localparam int MODE_W  = 4;
   localparam int SHIFT_W = 6;

   // Window count is at most 22, so a 5-bit count and divisor suffice.
   localparam int CNT_W = 5;

   // A sum of at most 22 values of magnitude 2^15 stays below 2^20.
   localparam int SUM_W  = 21;
   localparam int MAG_W  = SUM_W - 1;
   localparam int QUO_W  = 16;
   localparam int STEP_W = 4;

   localparam int NUM_MODES = 9;

   typedef struct packed {
      logic [FN_W-1:0]          fn;
      logic signed [VAL_W-1:0]  ci;
      logic signed [VAL_W-1:0]  toa;
      logic signed [RSSI_W-1:0] rssi;
   } meas_entry_type;

   function automatic logic mode_ok(input logic [MODE_W-1:0] mode);
      mode_ok = (mode < MODE_W'(NUM_MODES));
   endfunction

   function automatic logic [SHIFT_W-1:0] mode_shift(input logic [MODE_W-1:0] mode);
      logic [SHIFT_W-1:0] s;
      unique case (mode)
         4'd0:    s = 6'd24;
         4'd1:    s = 6'd22;
         4'd2:    s = 6'd4;
         4'd3:    s = 6'd8;
         4'd4:    s = 6'd6;
         4'd5:    s = 6'd6;
         4'd6:    s = 6'd8;
         4'd7:    s = 6'd6;
         4'd8:    s = 6'd4;
         default: s = 6'd0;
      endcase
      mode_shift = s;
   endfunction

   function automatic logic [CNT_W-1:0] mode_count(input logic [MODE_W-1:0] mode);
      logic [CNT_W-1:0] c;
      unique case (mode)
         4'd0:    c = 5'd22;
         4'd1:    c = 5'd22;
         4'd2:    c = 5'd4;
         4'd3:    c = 5'd8;
         4'd4:    c = 5'd4;
         4'd5:    c = 5'd6;
         4'd6:    c = 5'd4;
         4'd7:    c = 5'd2;
         4'd8:    c = 5'd2;
         default: c = 5'd1;
      endcase
      mode_count = c;
   endfunction

endpackage

`default_nettype wire

/* design/bmha_store.sv */
// Measurement history memory with one write port and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on bmha_pkg.
`default_nettype none

module bmha_store #(
   parameter int HIST_DEPTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          wr_en,
   input  wire [$clog2(HIST_DEPTH)-1:0] wr_idx,
   input  bmha_pkg::meas_entry_type     wr_data,
   input  wire                          rd_en,
   input  wire [$clog2(HIST_DEPTH)-1:0] rd_idx,
   output bmha_pkg::meas_entry_type     rd_data,
   output logic                         rd_valid
);

   bmha_pkg::meas_entry_type mem [HIST_DEPTH];

   logic [HIST_DEPTH-1:0]    valid_ff;
   logic [HIST_DEPTH-1:0]    valid_in;
   bmha_pkg::meas_entry_type rd_data_ff;
   logic                     rd_hit_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
         rd_hit_ff  <= valid_ff[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_en;
      end
   end

   // An entry never written since reset reads as all zeros.
   assign rd_data  = rd_hit_ff ? rd_data_ff : '0;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

/* design/bmha_div.sv */
// Shared iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on bmha_pkg for the sum, quotient and divisor widths.
`default_nettype none

module bmha_div (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   input  wire signed [bmha_pkg::SUM_W-1:0]       dividend,
   input  wire        [bmha_pkg::CNT_W-1:0]       divisor,
   output logic                                   done,
   output logic signed [bmha_pkg::QUO_W-1:0]      quotient
);

   localparam int SUM_W  = bmha_pkg::SUM_W;
   localparam int MAG_W  = bmha_pkg::MAG_W;
   localparam int QUO_W  = bmha_pkg::QUO_W;
   localparam int DVS_W  = bmha_pkg::CNT_W;
   localparam int STEP_W = bmha_pkg::STEP_W;
   localparam int HI_W   = MAG_W - QUO_W;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    shreg_ff, shreg_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [SUM_W-1:0]    mag;
   logic [DVS_W:0]      trial;
   logic                qbit;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      step_in  = step_ff;
      mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      trial    = {rem_ff, shreg_ff[QUO_W-1]};
      qbit     = (trial >= {1'b0, divisor});
      if (start) begin
         // The quotient fits in QUO_W bits, so the high part is already below the divisor.
         busy_in  = 1'b1;
         neg_in   = dividend[SUM_W-1];
         rem_in   = {{(DVS_W-HI_W){1'b0}}, mag[MAG_W-1:QUO_W]};
         shreg_in = mag[QUO_W-1:0];
         step_in  = STEP_W'(QUO_W - 1);
      end else if (busy_ff) begin
         rem_in   = qbit ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
         shreg_in = {shreg_ff[QUO_W-2:0], qbit};
         step_in  = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
      step_ff  <= step_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? QUO_W'(-shreg_ff) : shreg_ff;

endmodule

`default_nettype wire

/* design/burst_measurement_history_avg_top.sv */
// Burst measurement history with windowed averaging: sequencer, accumulators, result register.
// Depends on bmha_pkg, bmha_store and bmha_div.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  operation, frame_number, ci_valid, ci_centibel,
//                                               toa_256, rssi_dbm, avg_mode, lookup_back
//   rsp_      out        rsp_valid / rsp_stall  result_kind, first_fn, rssi_avg_q8, toa_avg, ci_avg
//
// A push is written in the cycle it is accepted; the block is ready again the next cycle.
// A lookup goes through one or two ring reductions at the default depth, a registered
// read and the output load. An average reads its window through the single-port history
// read and then runs the bit-serial divider once per field before the output load.
// Reset is synchronous and clears the pointer, the sequencer and every history valid bit.
// A finished result waits in the output register while the next request beat is taken.
`default_nettype none

module burst_measurement_history_avg_top #(
   parameter int HIST_DEPTH = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [1:0]        req_operation,
   input  wire  [21:0]       req_frame_number,
   input  wire               req_ci_valid,
   input  wire signed [15:0] req_ci_centibel,
   input  wire signed [15:0] req_toa_256,
   input  wire signed [7:0]  req_rssi_dbm,
   input  wire  [3:0]        req_avg_mode,
   input  wire  [5:0]        req_lookup_back,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_result_kind,
   output logic [21:0]       rsp_first_fn,
   output logic signed [15:0] rsp_rssi_avg_q8,
   output logic signed [15:0] rsp_toa_avg,
   output logic signed [15:0] rsp_ci_avg
);

   localparam int PTR_W  = $clog2(HIST_DEPTH);
   localparam int PTR_W1 = PTR_W + 1;
   localparam int SUM_W  = bmha_pkg::SUM_W;
   localparam int CNT_W  = bmha_pkg::CNT_W;
   localparam int QUO_W  = bmha_pkg::QUO_W;
   localparam int BACK_W = bmha_pkg::BACK_W;
   localparam int FN_W   = bmha_pkg::FN_W;
   localparam logic [BACK_W:0]  DEPTH_B = (BACK_W + 1)'(HIST_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_P = PTR_W1'(HIST_DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(HIST_DEPTH - 1);

   bmha_pkg::state_type state_ff, state_in;
   bmha_pkg::lane_type  lane_ff, lane_in;

   logic                    kind_ff, kind_in;
   logic [BACK_W-1:0]       back_ff, back_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [PTR_W-1:0]        idx_ff, idx_in;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic                    first_ff, first_in;
   logic [FN_W-1:0]         fn_ff, fn_in;
   logic signed [SUM_W-1:0] rssi_sum_ff, rssi_sum_in;
   logic signed [SUM_W-1:0] toa_sum_ff, toa_sum_in;
   logic signed [SUM_W-1:0] ci_sum_ff, ci_sum_in;
   logic                    div_issued_ff, div_issued_in;
   logic signed [QUO_W-1:0] rssi_q_ff, rssi_q_in;
   logic signed [QUO_W-1:0] toa_q_ff, toa_q_in;
   logic signed [QUO_W-1:0] ci_q_ff, ci_q_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [FN_W-1:0]         rsp_fn_ff, rsp_fn_in;
   logic signed [QUO_W-1:0] rsp_rssi_ff, rsp_rssi_in;
   logic signed [QUO_W-1:0] rsp_toa_ff, rsp_toa_in;
   logic signed [QUO_W-1:0] rsp_ci_ff, rsp_ci_in;

   logic                     accept;
   logic                     rsp_free;
   logic                     store_we;
   bmha_pkg::meas_entry_type store_wdata;
   logic                     rd_en;
   bmha_pkg::meas_entry_type rd_data;
   logic                     rd_valid;
   logic [PTR_W:0]           start_diff;

   logic                     div_start;
   logic signed [SUM_W-1:0]  div_dividend;
   logic                     div_done;
   logic signed [QUO_W-1:0]  div_quotient;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      store_wdata.fn   = req_frame_number;
      store_wdata.ci   = req_ci_valid ? req_ci_centibel : '0;
      store_wdata.toa  = req_toa_256;
      store_wdata.rssi = req_rssi_dbm;
   end

   always_comb begin
      state_in      = state_ff;
      lane_in       = lane_ff;
      kind_in       = kind_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      first_in      = first_ff;
      fn_in         = fn_ff;
      rssi_sum_in   = rssi_sum_ff;
      toa_sum_in    = toa_sum_ff;
      ci_sum_in     = ci_sum_ff;
      div_issued_in = div_issued_ff;
      rssi_q_in     = rssi_q_ff;
      toa_q_in      = toa_q_ff;
      ci_q_in       = ci_q_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_fn_in     = rsp_fn_ff;
      rsp_rssi_in   = rsp_rssi_ff;
      rsp_toa_in    = rsp_toa_ff;
      rsp_ci_in     = rsp_ci_ff;
      req_stall     = (state_ff != bmha_pkg::ST_IDLE);
      store_we      = 1'b0;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      start_diff    = {1'b0, wp_ff} - {1'b0, back_ff[PTR_W-1:0]};

      unique case (lane_ff)
         bmha_pkg::LANE_RSSI: div_dividend = rssi_sum_ff;
         bmha_pkg::LANE_TOA:  div_dividend = toa_sum_ff;
         bmha_pkg::LANE_CI:   div_dividend = ci_sum_ff;
         default:             div_dividend = ci_sum_ff;
      endcase

      unique case (state_ff)
         bmha_pkg::ST_IDLE: begin
            rssi_sum_in = '0;
            toa_sum_in  = '0;
            ci_sum_in   = '0;
            first_in    = 1'b1;
            lane_in     = bmha_pkg::LANE_RSSI;
            if (accept) begin
               unique case (req_operation)
                  bmha_pkg::OP_PUSH: begin
                     store_we = 1'b1;
                     wp_in    = (wp_ff == LAST_P) ? '0 : wp_ff + 1'b1;
                  end
                  bmha_pkg::OP_AVG: begin
                     if (bmha_pkg::mode_ok(req_avg_mode)) begin
                        kind_in  = bmha_pkg::KIND_AVG;
                        back_in  = bmha_pkg::mode_shift(req_avg_mode);
                        count_in = bmha_pkg::mode_count(req_avg_mode);
                        state_in = bmha_pkg::ST_REDUCE;
                     end
                  end
                  bmha_pkg::OP_LOOKUP: begin
                     kind_in  = bmha_pkg::KIND_LOOKUP;
                     back_in  = req_lookup_back;
                     count_in = CNT_W'(1);
                     state_in = bmha_pkg::ST_REDUCE;
                  end
                  default: begin
                     state_in = bmha_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         bmha_pkg::ST_REDUCE: begin
            // Fold the distance into the ring, then find the window's first entry.
            if ({1'b0, back_ff} >= DEPTH_B) begin
               back_in = BACK_W'({1'b0, back_ff} - DEPTH_B);
            end else begin
               idx_in   = start_diff[PTR_W] ? PTR_W'(start_diff + DEPTH_P)
                                            : start_diff[PTR_W-1:0];
               left_in  = count_ff;
               state_in = bmha_pkg::ST_READ;
            end
         end

         bmha_pkg::ST_READ: begin
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               left_in = left_ff - 1'b1;
               idx_in  = (idx_ff == LAST_P) ? '0 : idx_ff + 1'b1;
            end
            if (rd_valid) begin
               rssi_sum_in = rssi_sum_ff + {{(SUM_W-16){rd_data.rssi[7]}}, rd_data.rssi, 8'h00};
               toa_sum_in  = toa_sum_ff + {{(SUM_W-16){rd_data.toa[15]}}, rd_data.toa};
               ci_sum_in   = ci_sum_ff + {{(SUM_W-16){rd_data.ci[15]}}, rd_data.ci};
               if (first_ff) begin
                  fn_in    = rd_data.fn;
                  first_in = 1'b0;
               end
            end
            if (left_ff == '0 && !rd_valid) begin
               state_in = (kind_ff == bmha_pkg::KIND_LOOKUP) ? bmha_pkg::ST_OUT
                                                              : bmha_pkg::ST_DIV;
            end
         end

         bmha_pkg::ST_DIV: begin
            if (!div_issued_ff) begin
               div_start     = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               div_issued_in = 1'b0;
               unique case (lane_ff)
                  bmha_pkg::LANE_RSSI: begin
                     rssi_q_in = div_quotient;
                     lane_in   = bmha_pkg::LANE_TOA;
                  end
                  bmha_pkg::LANE_TOA: begin
                     toa_q_in = div_quotient;
                     lane_in  = bmha_pkg::LANE_CI;
                  end
                  default: begin
                     ci_q_in  = div_quotient;
                     state_in = bmha_pkg::ST_OUT;
                  end
               endcase
            end
         end

         bmha_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_fn_in    = fn_ff;
               if (kind_ff == bmha_pkg::KIND_LOOKUP) begin
                  rsp_rssi_in = '0;
                  rsp_toa_in  = '0;
                  rsp_ci_in   = '0;
               end else begin
                  rsp_rssi_in = rssi_q_ff;
                  rsp_toa_in  = toa_q_ff;
                  rsp_ci_in   = ci_q_ff;
               end
               state_in = bmha_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bmha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmha_pkg::ST_IDLE;
         lane_ff       <= bmha_pkg::LANE_RSSI;
         wp_ff         <= '0;
         left_ff       <= '0;
         div_issued_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lane_ff       <= lane_in;
         wp_ff         <= wp_in;
         left_ff       <= left_in;
         div_issued_ff <= div_issued_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      back_ff     <= back_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      fn_ff       <= fn_in;
      rssi_sum_ff <= rssi_sum_in;
      toa_sum_ff  <= toa_sum_in;
      ci_sum_ff   <= ci_sum_in;
      rssi_q_ff   <= rssi_q_in;
      toa_q_ff    <= toa_q_in;
      ci_q_ff     <= ci_q_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_fn_ff   <= rsp_fn_in;
      rsp_rssi_ff <= rsp_rssi_in;
      rsp_toa_ff  <= rsp_toa_in;
      rsp_ci_ff   <= rsp_ci_in;
   end

   bmha_store #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (store_we),
      .wr_idx   (wp_ff),
      .wr_data  (store_wdata),
      .rd_en    (rd_en),
      .rd_idx   (idx_ff),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   bmha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_first_fn    = rsp_fn_ff;
   assign rsp_rssi_avg_q8 = rsp_rssi_ff;
   assign rsp_toa_avg     = rsp_toa_ff;
   assign rsp_ci_avg      = rsp_ci_ff;

   // Read data from the history must only come back while the window is being walked.
   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid |-> (state_ff == bmha_pkg::ST_READ))
      else $error("history read data arrived outside the window walk");

   // The divider must only finish for a division the sequencer is waiting on.
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == bmha_pkg::ST_DIV && div_issued_ff))
      else $error("divider finished with no division outstanding");

   // A push must never overwrite history while a window is in progress.
   a_push_when_idle: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (state_ff == bmha_pkg::ST_IDLE))
      else $error("history written while busy");

   // The number of reads still to issue never exceeds the window length.
   a_left_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmha_pkg::ST_READ) |-> (left_ff <= count_ff))
      else $error("window read counter out of range");

   // Leaving the output state always leaves a beat in the result register.
   a_out_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmha_pkg::ST_OUT && rsp_free)
         |=> (rsp_valid_ff && state_ff == bmha_pkg::ST_IDLE))
      else $error("result not loaded when leaving the output state");

endmodule

`default_nettype wire

/* sim/burst_history_checker.sv */
// Checker for the burst measurement history averager: watches both channels,
// predicts every result from its own copy of the ring, and compares field by field.
// Depends on bmha_pkg for the entry type and the result kind codes.
module burst_history_checker #(
   parameter int HIST_DEPTH = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_stall,
   input  wire  [1:0]        req_operation,
   input  wire  [21:0]       req_frame_number,
   input  wire               req_ci_valid,
   input  wire signed [15:0] req_ci_centibel,
   input  wire signed [15:0] req_toa_256,
   input  wire signed [7:0]  req_rssi_dbm,
   input  wire  [3:0]        req_avg_mode,
   input  wire  [5:0]        req_lookup_back,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  wire               rsp_result_kind,
   input  wire  [21:0]       rsp_first_fn,
   input  wire signed [15:0] rsp_rssi_avg_q8,
   input  wire signed [15:0] rsp_toa_avg,
   input  wire signed [15:0] rsp_ci_avg,
   output int                error_count,
   output int                outstanding
);

   typedef struct {
      logic               kind;
      logic [21:0]        fn;
      logic signed [15:0] rssi_q8;
      logic signed [15:0] toa;
      logic signed [15:0] ci;
   } window_result_type;

   bmha_pkg::meas_entry_type history [HIST_DEPTH];
   int                       wr_ptr;
   window_result_type        pending_results [$];
   int                       fails;

   initial begin
      error_count = 0;
      outstanding = 0;
      fails = 0;
      wr_ptr = 0;
   end

   // Ring slot that lies 'back' places behind the write pointer, then 'fwd' ahead.
   function automatic int ring_slot(input int back, input int fwd);
      return (wr_ptr + HIST_DEPTH - (back % HIST_DEPTH) + fwd) % HIST_DEPTH;
   endfunction

   // Window geometry for each averaging mode; false for an undefined mode.
   function automatic bit window_geometry(input logic [3:0] mode, output int shift,
                                          output int len);
      shift = 0;
      len = 1;
      case (mode)
         4'd0: begin shift = 24; len = 22; end
         4'd1: begin shift = 22; len = 22; end
         4'd2: begin shift = 4;  len = 4;  end
         4'd3: begin shift = 8;  len = 8;  end
         4'd4: begin shift = 6;  len = 4;  end
         4'd5: begin shift = 6;  len = 6;  end
         4'd6: begin shift = 8;  len = 4;  end
         4'd7: begin shift = 6;  len = 2;  end
         4'd8: begin shift = 4;  len = 2;  end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic report_failure(input string msg);
      $display("burst_history_checker: %0t: %s", $time, msg);
      fails++;
   endtask

   task automatic predict_beat();
      window_result_type        res;
      bmha_pkg::meas_entry_type ent;
      int shift, len, sum_rssi, sum_toa, sum_ci;
      case (req_operation)
         bmha_pkg::OP_PUSH: begin
            ent.fn   = req_frame_number;
            ent.ci   = req_ci_valid ? req_ci_centibel : 16'sd0;
            ent.toa  = req_toa_256;
            ent.rssi = req_rssi_dbm;
            history[wr_ptr] = ent;
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
         end
         bmha_pkg::OP_AVG: begin
            if (window_geometry(req_avg_mode, shift, len)) begin
               sum_rssi = 0;
               sum_toa = 0;
               sum_ci = 0;
               for (int i = 0; i < len; i++) begin
                  ent = history[ring_slot(shift, i)];
                  sum_rssi += int'($signed(ent.rssi)) * 256;
                  sum_toa  += int'($signed(ent.toa));
                  sum_ci   += int'($signed(ent.ci));
               end
               res.kind    = bmha_pkg::KIND_AVG;
               res.fn      = history[ring_slot(shift, 0)].fn;
               // Integer division truncates toward zero, as the block must.
               res.rssi_q8 = 16'(sum_rssi / len);
               res.toa     = 16'(sum_toa / len);
               res.ci      = 16'(sum_ci / len);
               pending_results.push_back(res);
            end
         end
         bmha_pkg::OP_LOOKUP: begin
            res.kind    = bmha_pkg::KIND_LOOKUP;
            res.fn      = history[ring_slot(int'(req_lookup_back), 0)].fn;
            res.rssi_q8 = '0;
            res.toa     = '0;
            res.ci      = '0;
            pending_results.push_back(res);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         foreach (history[i]) history[i] = '0;
         wr_ptr = 0;
         pending_results.delete();
      end else begin
         // A result accepted at this edge always belongs to an older request beat.
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_failure($sformatf("result beat with nothing expected, fn %0d",
                                        rsp_first_fn));
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_failure($sformatf("result_kind got %0d, expected %0d",
                                           rsp_result_kind, want.kind));
               if (rsp_first_fn !== want.fn)
                  report_failure($sformatf("first_fn got %0d, expected %0d",
                                           rsp_first_fn, want.fn));
               if (rsp_rssi_avg_q8 !== want.rssi_q8)
                  report_failure($sformatf("rssi_avg_q8 got %0d, expected %0d",
                                           rsp_rssi_avg_q8, want.rssi_q8));
               if (rsp_toa_avg !== want.toa)
                  report_failure($sformatf("toa_avg got %0d, expected %0d",
                                           rsp_toa_avg, want.toa));
               if (rsp_ci_avg !== want.ci)
                  report_failure($sformatf("ci_avg got %0d, expected %0d",
                                           rsp_ci_avg, want.ci));
            end
         end
         if (req_valid && !req_stall) predict_beat();
      end
      error_count <= fails;
      outstanding <= pending_results.size();
   end

endmodule

/* sim/burst_measurement_history_avg_top_tb.sv */
// Testbench top for the burst measurement history averager: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on bmha_pkg, the block
// and burst_history_checker, which does all prediction and comparison.
module burst_measurement_history_avg_top_tb;

   localparam int          ITEM_TARGET  = 1750;
   localparam int          LIMIT_CYCLES = 600000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          MODE_COUNT   = 9;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [21:0] FN_MAX       = 22'd2715647;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic [21:0]        req_frame_number;
   logic               req_ci_valid;
   logic signed [15:0] req_ci_centibel;
   logic signed [15:0] req_toa_256;
   logic signed [7:0]  req_rssi_dbm;
   logic [3:0]         req_avg_mode;
   logic [5:0]         req_lookup_back;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_result_kind;
   logic [21:0]        rsp_first_fn;
   logic signed [15:0] rsp_rssi_avg_q8;
   logic signed [15:0] rsp_toa_avg;
   logic signed [15:0] rsp_ci_avg;
   int                 error_count;
   int                 outstanding;
   int                 cycle_count = 0;
   int                 beats_counted = 0;
   bit                 steady = 1'b0;
   bit                 hold_off_go = 1'b0;

   always #6 clock = ~clock;

   burst_measurement_history_avg_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_frame_number (req_frame_number),
      .req_ci_valid     (req_ci_valid),
      .req_ci_centibel  (req_ci_centibel),
      .req_toa_256      (req_toa_256),
      .req_rssi_dbm     (req_rssi_dbm),
      .req_avg_mode     (req_avg_mode),
      .req_lookup_back  (req_lookup_back),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_first_fn     (rsp_first_fn),
      .rsp_rssi_avg_q8  (rsp_rssi_avg_q8),
      .rsp_toa_avg      (rsp_toa_avg),
      .rsp_ci_avg       (rsp_ci_avg)
   );

   burst_history_checker i_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_frame_number (req_frame_number),
      .req_ci_valid     (req_ci_valid),
      .req_ci_centibel  (req_ci_centibel),
      .req_toa_256      (req_toa_256),
      .req_rssi_dbm     (req_rssi_dbm),
      .req_avg_mode     (req_avg_mode),
      .req_lookup_back  (req_lookup_back),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_first_fn     (rsp_first_fn),
      .rsp_rssi_avg_q8  (rsp_rssi_avg_q8),
      .rsp_toa_avg      (rsp_toa_avg),
      .rsp_ci_avg       (rsp_ci_avg),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("burst_measurement_history_avg_top_tb: done, errors");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off once the sender asks for it.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 10);
      end
   end

   function automatic logic signed [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [7:0] pick_rssi();
      case ($urandom_range(0, 7))
         0: return -8'sd128;
         1: return 8'sd127;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offers one request beat and returns once it is taken and the block no longer stalls.
   // Valid stays high afterwards; back-to-back beats drop it only for the random gaps outside the steady phase.
   task automatic send_beat(input logic [1:0] op, input logic [21:0] fn, input logic civ,
                            input logic signed [15:0] ci, input logic signed [15:0] toa,
                            input logic signed [7:0] rssi, input logic [3:0] mode,
                            input logic [5:0] back);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_frame_number <= fn;
      req_ci_valid     <= civ;
      req_ci_centibel  <= ci;
      req_toa_256      <= toa;
      req_rssi_dbm     <= rssi;
      req_avg_mode     <= mode;
      req_lookup_back  <= back;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic push_beat(input logic [21:0] fn, input logic civ,
                            input logic signed [15:0] ci, input logic signed [15:0] toa,
                            input logic signed [7:0] rssi);
      send_beat(bmha_pkg::OP_PUSH, fn, civ, ci, toa, rssi, 4'($urandom), 6'($urandom));
   endtask

   task automatic average_beat(input logic [3:0] mode);
      send_beat(bmha_pkg::OP_AVG, 22'($urandom), 1'($urandom), pick_word(), pick_word(),
                pick_rssi(), mode, 6'($urandom));
   endtask

   task automatic lookup_beat(input logic [5:0] back);
      send_beat(bmha_pkg::OP_LOOKUP, 22'($urandom), 1'($urandom), pick_word(), pick_word(),
                pick_rssi(), 4'($urandom), back);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic signed [15:0] ci_fill, toa_fill;
      logic signed [7:0]  rssi_fill;
      logic [21:0]        fn_fill;
      int                 pick;
      bit                 paused;

      paused = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = bmha_pkg::OP_PUSH;
      req_frame_number = '0;
      req_ci_valid = 1'b0;
      req_ci_centibel = '0;
      req_toa_256 = '0;
      req_rssi_dbm = '0;
      req_avg_mode = '0;
      req_lookup_back = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reads of the cleared store, field extremes, C/I without its valid
      // flag, every mode, lookups beyond the depth, undefined mode and operation.
      lookup_beat(6'd0);
      average_beat(4'd0);
      push_beat(22'd0, 1'b1, -16'sd32768, -16'sd32768, -8'sd128);
      push_beat(FN_MAX, 1'b1, 16'sd32767, 16'sd32767, 8'sd127);
      push_beat(22'h155555, 1'b0, 16'sh1234, -16'sd5, -8'sd1);
      for (int m = 0; m < MODE_COUNT; m++) average_beat(4'(m));
      lookup_beat(6'd1);
      lookup_beat(6'd3);
      lookup_beat(6'd32);
      average_beat(4'(MODE_COUNT));
      average_beat(4'd15);
      send_beat(OP_UNUSED, FN_MAX, 1'b1, -16'sd1, -16'sd1, -8'sd1, 4'd2, 6'd2);

      while (beats_counted < ITEM_TARGET) begin
         steady = (beats_counted >= 1200) && (beats_counted < 1450);
         if (beats_counted >= 500) hold_off_go = 1'b1;
         if (beats_counted >= 1000 && !paused) begin
            paused = 1'b1;
            wait_for_results();
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // A full window of one extreme value drives the sums to their limits.
            fn_fill   = 22'($urandom_range(0, FN_MAX));
            ci_fill   = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
            toa_fill  = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
            rssi_fill = $urandom_range(0, 1) ? -8'sd128 : 8'sd127;
            repeat (24) push_beat(fn_fill, 1'b1, ci_fill, toa_fill, rssi_fill);
            average_beat(4'($urandom_range(0, 1)));
            beats_counted += 25;
         end else if (pick < 50) begin
            push_beat(22'($urandom_range(0, FN_MAX)), 1'($urandom), pick_word(),
                      pick_word(), pick_rssi());
            beats_counted++;
         end else if (pick < 78) begin
            average_beat(4'($urandom_range(0, MODE_COUNT - 1)));
            beats_counted++;
         end else if (pick < 95) begin
            lookup_beat(6'($urandom_range(0, 32)));
            beats_counted++;
         end else if (pick < 97) begin
            send_beat(OP_UNUSED, 22'($urandom_range(0, FN_MAX)), 1'($urandom), pick_word(),
                      pick_word(), pick_rssi(), 4'($urandom), 6'($urandom));
         end else begin
            average_beat(4'($urandom_range(MODE_COUNT, 15)));
         end
      end
      steady = 1'b0;

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("burst_measurement_history_avg_top_tb: done, clean");
      end else begin
         $display("burst_measurement_history_avg_top_tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
design/bmha_pkg.sv
design/bmha_store.sv
design/bmha_div.sv
design/burst_measurement_history_avg_top.sv
sim/burst_history_checker.sv
sim/burst_measurement_history_avg_top_tb.sv
